### rtl/core/crc8_checked_frame_parser_core_assert.svh
// Assertion macros shared by the RTL. All of them sample on clk_i and are
// disabled while rst_ni is low.
`ifndef CRC8_CHECKED_FRAME_PARSER_CORE_ASSERT_SVH
`define CRC8_CHECKED_FRAME_PARSER_CORE_ASSERT_SVH

// The condition must never be true.
`define CRC8FP_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

// The consequent must hold in the same cycle as the antecedent.
`define CRC8FP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// The consequent must hold in the cycle after the antecedent.
`define CRC8FP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

### rtl/core/crc8fp_pkg.sv
package crc8fp_pkg;

  localparam logic [7:0] SYNC_BYTE    = 8'hA5;
  localparam logic [7:0] VERSION_BYTE = 8'h01;
  localparam logic [7:0] CRC_POLY     = 8'h07;
  localparam int unsigned RESULT_LIMIT = 32;

  typedef enum logic [1:0] {
    ST_NEED_MORE = 2'd0,
    ST_REJECT    = 2'd1,
    ST_DONE      = 2'd2
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [5:0]  consumed;
    logic [5:0]  payload_length;
    logic [7:0]  payload_byte;
    logic [4:0]  payload_index;
    logic        last;
  } result_t;

  typedef struct packed {
    logic accept;
    logic burst_load;
  } cmd_t;

  typedef struct packed {
    logic burst_start;
    logic burst_last;
    logic out_free;
  } stat_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  localparam logic [7:0] SYNC_CRC = crc8_update(8'h00, SYNC_BYTE);

endpackage

### rtl/core/crc8fp_byte_if.sv
interface crc8fp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

### rtl/core/crc8fp_result_if.sv
interface crc8fp_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [5:0] consumed;
  logic [5:0] payload_length;
  logic [7:0] payload_byte;
  logic [4:0] payload_index;
  logic       last;

  modport source (
    output valid, output status, output consumed, output payload_length,
    output payload_byte, output payload_index, output last, input ready
  );
  modport sink (
    input valid, input status, input consumed, input payload_length,
    input payload_byte, input payload_index, input last, output ready
  );
endinterface

### rtl/core/crc8fp_ram.sv
module crc8fp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/crc8fp_ctrl.sv
module crc8fp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  crc8fp_pkg::stat_t  stat_i,
  output crc8fp_pkg::cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    S_RUN  = 3'b001,
    S_RD   = 3'b010,
    S_SEND = 3'b100
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o       = (state_q == S_RUN) && stat_i.out_free;
  assign cmd_o.accept     = in_valid_i && in_ready_o;
  assign cmd_o.burst_load = (state_q == S_SEND) && stat_i.out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_RUN: begin
        if (cmd_o.accept && stat_i.burst_start) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_SEND;
      end
      S_SEND: begin
        if (cmd_o.burst_load) begin
          state_d = stat_i.burst_last ? S_RUN : S_RD;
        end
      end
      default: begin
        state_d = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RUN;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/core/crc8fp_dpath.sv
module crc8fp_dpath #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           data_byte_i,
  input  logic                 out_ready_i,
  input  crc8fp_pkg::cmd_t     cmd_i,
  output crc8fp_pkg::stat_t    stat_o,
  output logic                 out_valid_o,
  output crc8fp_pkg::result_t  result_o
);

  localparam int unsigned HW = $clog2(MAX_PAYLOAD + 5);
  localparam int unsigned LW = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int unsigned CW = (LW > 6) ? LW : 6;

  logic [HW-1:0] bh_q, bh_d;
  logic [7:0]    crc_q, crc_d;
  logic [LW-1:0] plen_q, plen_d;
  logic [4:0]    k_q, k_d;
  logic          out_valid_q, out_valid_d;
  crc8fp_pkg::result_t out_q, out_d, res;

  logic [7:0]    crc_next;
  logic          is_sync;
  logic [HW-1:0] restart_bh;
  logic [7:0]    restart_crc;
  logic [HW-1:0] pl_end;
  logic [HW-1:0] total;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    rdata;
  logic          burst_start;
  logic          burst_last;
  logic          out_free;

  assign crc_next    = crc8fp_pkg::crc8_update(crc_q, data_byte_i);
  assign is_sync     = (data_byte_i == crc8fp_pkg::SYNC_BYTE);
  assign restart_bh  = is_sync ? HW'(1) : '0;
  assign restart_crc = is_sync ? crc8fp_pkg::SYNC_CRC : 8'h00;
  assign pl_end      = HW'(plen_q) + HW'(3);
  assign total       = HW'(plen_q) + HW'(4);
  assign waddr       = AW'(bh_q - HW'(3));
  assign out_free    = !out_valid_q || out_ready_i;
  assign burst_last  = ((CW'(k_q) + CW'(1)) == CW'(plen_q)) ||
                       (k_q == 5'(crc8fp_pkg::RESULT_LIMIT - 1));

  crc8fp_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (data_byte_i),
    .raddr_i (AW'(k_q)),
    .rdata_o (rdata)
  );

  always_comb begin
    bh_d        = bh_q;
    crc_d       = crc_q;
    plen_d      = plen_q;
    k_d         = k_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    we          = 1'b0;
    burst_start = 1'b0;

    res.status         = crc8fp_pkg::ST_NEED_MORE;
    res.consumed       = 6'd1;
    res.payload_length = '0;
    res.payload_byte   = '0;
    res.payload_index  = '0;
    res.last           = 1'b1;

    if (cmd_i.accept) begin
      if (bh_q == '0) begin
        if (!is_sync) begin
          res.status = crc8fp_pkg::ST_REJECT;
        end else begin
          bh_d  = HW'(1);
          crc_d = crc_next;
        end
      end else if ((bh_q == HW'(1) && data_byte_i != crc8fp_pkg::VERSION_BYTE) ||
                   (bh_q == HW'(2) && data_byte_i > 8'(MAX_PAYLOAD))) begin
        bh_d       = restart_bh;
        crc_d      = restart_crc;
        res.status = crc8fp_pkg::ST_REJECT;
      end else if (bh_q < HW'(3)) begin
        if (bh_q == HW'(2)) begin
          plen_d = LW'(data_byte_i);
        end
        crc_d  = crc_next;
        bh_d   = bh_q + HW'(1);
      end else if (bh_q < pl_end) begin
        we    = 1'b1;
        crc_d = crc_next;
        bh_d  = bh_q + HW'(1);
      end else if (data_byte_i != crc_q) begin
        bh_d         = restart_bh;
        crc_d        = restart_crc;
        res.status   = crc8fp_pkg::ST_REJECT;
        res.consumed = 6'(total);
      end else begin
        bh_d  = '0;
        crc_d = 8'h00;
        if (plen_q == '0) begin
          res.status   = crc8fp_pkg::ST_DONE;
          res.consumed = 6'(total);
        end else begin
          burst_start = 1'b1;
          k_d         = '0;
        end
      end
      if (!burst_start) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end
    end else if (cmd_i.burst_load) begin
      out_d.status         = crc8fp_pkg::ST_DONE;
      out_d.consumed       = 6'(total);
      out_d.payload_length = 6'(plen_q);
      out_d.payload_byte   = rdata;
      out_d.payload_index  = k_q;
      out_d.last           = burst_last;
      out_valid_d          = 1'b1;
      k_d                  = k_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bh_q        <= '0;
      crc_q       <= 8'h00;
      out_valid_q <= 1'b0;
    end else begin
      bh_q        <= bh_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    plen_q <= plen_d;
    k_q    <= k_d;
    out_q  <= out_d;
  end

  assign stat_o.burst_start = burst_start;
  assign stat_o.burst_last  = burst_last;
  assign stat_o.out_free    = out_free;
  assign out_valid_o        = out_valid_q;
  assign result_o           = out_q;

endmodule

### rtl/core/crc8_checked_frame_parser_core.sv
// Byte-stream frame parser with a CRC-8/SMBUS check (polynomial 0x07, initial
// value 0). Frames are sync 0xA5, version 0x01, a payload length of at most
// MAX_PAYLOAD, the payload and one CRC byte covering all earlier bytes. Each
// byte that does not complete a good frame gives one transaction on the
// result channel: need-more, or a reject that reports how many bytes it
// consumed. A good frame with N payload bytes gives min(N, 32) payload
// transactions, or one done transaction when N is 0; each payload
// transaction passes the read state and then the send state, because the
// payload store has a registered read port. No byte is taken during that
// readout. A stalled result waits in an output register, and the next
// byte is taken in the same cycle that the pending result is taken. The
// payload store needs no clearing after reset.
`include "crc8_checked_frame_parser_core_assert.svh"

module crc8_checked_frame_parser_core #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  crc8fp_byte_if.sink      in_i,
  crc8fp_result_if.source  out_o
);

  crc8fp_pkg::cmd_t    cmd;
  crc8fp_pkg::stat_t   stat;
  crc8fp_pkg::result_t result;
  logic                out_valid;

  crc8fp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  crc8fp_dpath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .data_byte_i (in_i.data_byte),
    .out_ready_i (out_o.ready),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid),
    .result_o    (result)
  );

  assign out_o.valid          = out_valid;
  assign out_o.status         = result.status;
  assign out_o.consumed       = result.consumed;
  assign out_o.payload_length = result.payload_length;
  assign out_o.payload_byte   = result.payload_byte;
  assign out_o.payload_index  = result.payload_index;
  assign out_o.last           = result.last;

  `CRC8FP_ASSERT_NEVER(a_no_accept_in_readout, cmd.accept && cmd.burst_load)
  `CRC8FP_ASSERT_IMPL(a_load_only_when_free, cmd.burst_load, stat.out_free)
  `CRC8FP_ASSERT_NEXT(a_busy_after_good_frame, cmd.accept && stat.burst_start, !in_i.ready)

endmodule
